// File: rtl/psched_pkg.sv
`default_nettype none
package psched_pkg;

    localparam int MAX_JOBS   = 16;
    localparam int BURST_BITS = 16;
    localparam int CNT_W      = $clog2(MAX_JOBS + 1);
    localparam int IDX_W      = $clog2(MAX_JOBS);
    localparam int ELAP_W     = BURST_BITS + CNT_W;
    localparam int SUM_W      = ELAP_W + CNT_W;
    localparam int NUM_W      = SUM_W + 8;
    localparam int DCNT_W     = $clog2(NUM_W + 1);
    localparam int JOBNUM_W   = 5;
    localparam int PRIO_W     = 8;
    localparam int TIME_W     = 20;
    localparam int AVG_W      = 28;

    // commands from the controller to the datapath
    typedef struct packed {
        logic insert;
        logic sum_start;
        logic sum_step;
        logic div_init;
        logic div_step;
        logic out_load;
        logic finish;
    } ctl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic idx_last;
        logic div_last;
        logic out_free;
    } ctl_stat_t;

endpackage
`default_nettype wire

// File: rtl/psched_ctrl.sv
`default_nettype none
module psched_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  batch_last,
    input  wire psched_pkg::ctl_stat_t stat,
    output logic                       in_stall,
    output psched_pkg::ctl_cmd_t       cmd
);
    import psched_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_SUM   = 5'b00010,
        S_DINIT = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_LOAD);
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.insert = 1'b1;
                    if (batch_last)
                    begin
                        cmd.sum_start = 1'b1;
                        state_next    = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (stat.idx_last)
                    state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.idx_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/psched_datapath.sv
`default_nettype none
module psched_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire psched_pkg::ctl_cmd_t                  cmd,
    output psched_pkg::ctl_stat_t                      stat,
    input  wire logic [15:0]                           burst_time,
    input  wire logic [psched_pkg::PRIO_W-1:0]         job_priority,
    input  wire logic                                  out_stall,
    output logic                                       out_valid,
    output logic [psched_pkg::JOBNUM_W-1:0]            job_number,
    output logic [psched_pkg::PRIO_W-1:0]              job_priority_out,
    output logic [15:0]                                burst_time_out,
    output logic [psched_pkg::TIME_W-1:0]              wait_time,
    output logic [psched_pkg::TIME_W-1:0]              turnaround_time,
    output logic [psched_pkg::AVG_W-1:0]               avg_wait_q8,
    output logic [psched_pkg::AVG_W-1:0]               avg_turnaround_q8,
    output logic                                       run_last
);
    import psched_pkg::*;

    // sorted job table
    logic [BURST_BITS-1:0] tbl_burst_reg [MAX_JOBS];
    logic [BURST_BITS-1:0] tbl_burst_next[MAX_JOBS];
    logic [PRIO_W-1:0]     tbl_prio_reg  [MAX_JOBS];
    logic [PRIO_W-1:0]     tbl_prio_next [MAX_JOBS];
    logic [JOBNUM_W-1:0]   tbl_num_reg   [MAX_JOBS];
    logic [JOBNUM_W-1:0]   tbl_num_next  [MAX_JOBS];
    logic [BURST_BITS-1:0] prev_burst    [MAX_JOBS];
    logic [PRIO_W-1:0]     prev_prio     [MAX_JOBS];
    logic [JOBNUM_W-1:0]   prev_num      [MAX_JOBS];
    logic [MAX_JOBS-1:0]   gt;
    logic [MAX_JOBS-1:0]   gt_prev;
    logic [CNT_W:0]        num_full;
    logic [BURST_BITS-1:0] new_burst;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ELAP_W-1:0] elap_reg, elap_next;
    logic [SUM_W-1:0]  wsum_reg, wsum_next;
    logic [SUM_W-1:0]  tsum_reg, tsum_next;
    logic [ELAP_W-1:0] elap_add;

    // dividers
    logic [NUM_W-1:0]  qw_reg, qw_next, qt_reg, qt_next;
    logic [CNT_W-1:0]  rw_reg, rw_next, rt_reg, rt_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [CNT_W:0]    trial_w, trial_t;
    logic              ge_w, ge_t;

    logic out_valid_reg, out_valid_next;
    logic [JOBNUM_W-1:0]   onum_reg;
    logic [PRIO_W-1:0]     oprio_reg;
    logic [BURST_BITS-1:0] oburst_reg;
    logic [TIME_W-1:0]     owait_reg, oturn_reg;
    logic [AVG_W-1:0]      oavgw_reg, oavgt_reg;
    logic                  olast_reg;

    logic [BURST_BITS-1:0] sel_burst;

    assign new_burst = burst_time[BURST_BITS-1:0];
    assign num_full  = {1'b0, count_reg} + 1'b1;
    assign sel_burst = tbl_burst_reg[idx_reg];
    assign elap_add  = elap_reg + ELAP_W'(sel_burst);

    // status
    assign stat.idx_last = ((CNT_W'(idx_reg) + 1'b1) == count_reg);
    assign stat.div_last = (dcnt_reg == DCNT_W'(1));
    assign stat.out_free = !out_valid_reg || !out_stall;

    // insertion: entries with larger priority move up one place
    always_comb
    begin
        for (int k = 0; k < MAX_JOBS; k++)
        begin
            gt[k] = (CNT_W'(k) < count_reg) && (tbl_prio_reg[k] > job_priority);
        end
        gt_prev       = {gt[MAX_JOBS-2:0], 1'b0};
        prev_burst[0] = '0;
        prev_prio[0]  = '0;
        prev_num[0]   = '0;
        for (int k = 1; k < MAX_JOBS; k++)
        begin
            prev_burst[k] = tbl_burst_reg[k-1];
            prev_prio[k]  = tbl_prio_reg[k-1];
            prev_num[k]   = tbl_num_reg[k-1];
        end
        for (int k = 0; k < MAX_JOBS; k++)
        begin
            tbl_burst_next[k] = tbl_burst_reg[k];
            tbl_prio_next[k]  = tbl_prio_reg[k];
            tbl_num_next[k]   = tbl_num_reg[k];
            if (cmd.insert && (count_reg < CNT_W'(MAX_JOBS)))
            begin
                if (gt_prev[k])
                begin
                    tbl_burst_next[k] = prev_burst[k];
                    tbl_prio_next[k]  = prev_prio[k];
                    tbl_num_next[k]   = prev_num[k];
                end
                else if ((CNT_W'(k) <= count_reg) &&
                         ((CNT_W'(k) == count_reg) || gt[k]))
                begin
                    tbl_burst_next[k] = new_burst;
                    tbl_prio_next[k]  = job_priority;
                    tbl_num_next[k]   = JOBNUM_W'(num_full);
                end
            end
        end
    end

    // table storage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_JOBS; k++)
        begin
            tbl_burst_reg[k] <= tbl_burst_next[k];
            tbl_prio_reg[k]  <= tbl_prio_next[k];
            tbl_num_reg[k]   <= tbl_num_next[k];
        end
    end

    // divider bit step
    assign trial_w = {rw_reg, qw_reg[NUM_W-1]};
    assign trial_t = {rt_reg, qt_reg[NUM_W-1]};
    assign ge_w    = (trial_w >= {1'b0, count_reg});
    assign ge_t    = (trial_t >= {1'b0, count_reg});

    // count, index, sums and dividers
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        elap_next  = elap_reg;
        wsum_next  = wsum_reg;
        tsum_next  = tsum_reg;
        qw_next    = qw_reg;
        qt_next    = qt_reg;
        rw_next    = rw_reg;
        rt_next    = rt_reg;
        dcnt_next  = dcnt_reg;
        if (cmd.insert && (count_reg < CNT_W'(MAX_JOBS)))
            count_next = count_reg + 1'b1;
        if (cmd.sum_start)
        begin
            idx_next  = '0;
            elap_next = '0;
            wsum_next = '0;
            tsum_next = '0;
        end
        if (cmd.sum_step)
        begin
            idx_next  = idx_reg + 1'b1;
            elap_next = elap_add;
            wsum_next = wsum_reg + SUM_W'(elap_reg);
            tsum_next = tsum_reg + SUM_W'(elap_add);
        end
        if (cmd.div_init)
        begin
            idx_next  = '0;
            elap_next = '0;
            qw_next   = {wsum_reg, 8'd0};
            qt_next   = {tsum_reg, 8'd0};
            rw_next   = '0;
            rt_next   = '0;
            dcnt_next = DCNT_W'(NUM_W);
        end
        if (cmd.div_step)
        begin
            qw_next   = {qw_reg[NUM_W-2:0], ge_w};
            qt_next   = {qt_reg[NUM_W-2:0], ge_t};
            rw_next   = ge_w ? CNT_W'(trial_w - {1'b0, count_reg}) : CNT_W'(trial_w);
            rt_next   = ge_t ? CNT_W'(trial_t - {1'b0, count_reg}) : CNT_W'(trial_t);
            dcnt_next = dcnt_reg - 1'b1;
        end
        if (cmd.out_load)
        begin
            idx_next  = idx_reg + 1'b1;
            elap_next = elap_add;
        end
        if (cmd.finish)
            count_next = '0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        elap_reg <= elap_next;
        wsum_reg <= wsum_next;
        tsum_reg <= tsum_next;
        qw_reg   <= qw_next;
        qt_reg   <= qt_next;
        rw_reg   <= rw_next;
        rt_reg   <= rt_next;
        dcnt_reg <= dcnt_next;
    end

    // output register
    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            onum_reg   <= tbl_num_reg[idx_reg];
            oprio_reg  <= tbl_prio_reg[idx_reg];
            oburst_reg <= sel_burst;
            owait_reg  <= TIME_W'(elap_reg);
            oturn_reg  <= TIME_W'(elap_add);
            oavgw_reg  <= AVG_W'(qw_reg);
            oavgt_reg  <= AVG_W'(qt_reg);
            olast_reg  <= stat.idx_last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign job_number        = onum_reg;
    assign job_priority_out  = oprio_reg;
    assign burst_time_out    = 16'(oburst_reg);
    assign wait_time         = owait_reg;
    assign turnaround_time   = oturn_reg;
    assign avg_wait_q8       = oavgw_reg;
    assign avg_turnaround_q8 = oavgt_reg;
    assign run_last          = olast_reg;

endmodule
`default_nettype wire

// File: rtl/priority_schedule_timing_unit.sv
// channel  handshake             payload
// in       in_valid / in_stall   burst_time, job_priority, batch_last
// out      out_valid / out_stall job_number, job_priority_out, burst_time_out,
//                                wait_time, turnaround_time, avg_wait_q8,
//                                avg_turnaround_q8, run_last
//
// a job is sorted into the table when it is accepted; in_stall is low while loading
// a last job starts a run: summing over the jobs, a setup step, bit-serial
// division for the means, then one result per cycle when not stalled
// in_stall stays high from the last job until the final result is loaded
// out_stall holds the output register; reset clears the job count, the state
// and the output valid
`default_nettype none
module priority_schedule_timing_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] burst_time,
    input  wire logic [7:0]  job_priority,
    input  wire logic        batch_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       job_number,
    output logic [7:0]       job_priority_out,
    output logic [15:0]      burst_time_out,
    output logic [19:0]      wait_time,
    output logic [19:0]      turnaround_time,
    output logic [27:0]      avg_wait_q8,
    output logic [27:0]      avg_turnaround_q8,
    output logic             run_last
);
    import psched_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    // sequencer
    psched_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .batch_last (batch_last),
        .stat       (stat),
        .in_stall   (in_stall),
        .cmd        (cmd)
    );

    // table, sums, dividers and output register
    psched_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .burst_time        (burst_time),
        .job_priority      (job_priority),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .job_number        (job_number),
        .job_priority_out  (job_priority_out),
        .burst_time_out    (burst_time_out),
        .wait_time         (wait_time),
        .turnaround_time   (turnaround_time),
        .avg_wait_q8       (avg_wait_q8),
        .avg_turnaround_q8 (avg_turnaround_q8),
        .run_last          (run_last)
    );

endmodule
`default_nettype wire
